FILE: hw/rtl/pts_pkg.sv
// Shared constants, codes and controller/datapath interface types of the task scheduler.
package pts_pkg;

	localparam int TASK_SLOTS  = 16;
	localparam int PRIO_LEVELS = 8;
	localparam int TASK_W      = $clog2(TASK_SLOTS);
	localparam int PRIO_W      = $clog2(PRIO_LEVELS);

	typedef enum logic [2:0] {
		MODE_CREATE    = 3'd0,
		MODE_START     = 3'd1,
		MODE_YIELD     = 3'd2,
		MODE_SUSPEND   = 3'd3,
		MODE_RESUME    = 3'd4,
		MODE_TERMINATE = 3'd5,
		MODE_SET_PRIO  = 3'd6,
		MODE_QUERY     = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		ST_DORMANT   = 2'd0,
		ST_READY     = 2'd1,
		ST_SUSPENDED = 2'd2
	} slot_state_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_NO_TASK = 2'd1,
		STS_NO_FREE = 2'd2,
		STS_ILLEGAL = 2'd3
	} status_t;

	typedef struct packed {
		logic        capture;
		logic        set_code;
		status_t     code;
		logic        res_zero;
		logic        res_free;
		logic        wr_state;
		slot_state_t state_val;
		logic        wr_prio;
		logic        remove;
		logic        append;
		logic        app_cur;
		logic        pick;
		logic        set_on;
		logic        query;
		logic        load_out;
	} dp_cmd_t;

	typedef struct packed {
		mode_t       mode;
		logic        id_bad;
		slot_state_t tgt_state;
		logic        running_target;
		logic        sched_on;
		logic        busy;
		logic        cur_ready;
		logic        free_found;
	} dp_sts_t;

endpackage

FILE: hw/rtl/pts_datapath.sv
// Task table, linked ready queues, pick logic and result registers.
module pts_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pts_pkg::dp_cmd_t      cmd,
	output pts_pkg::dp_sts_t      sts,
	input  logic [2:0]            mode,
	input  logic [3:0]            task_id,
	input  logic [2:0]            priority_req,
	output logic [1:0]            status_code,
	output logic [3:0]            result_task,
	output logic [3:0]            running_task,
	output logic                  switched,
	output logic                  none_ready,
	output logic [1:0]            task_state_out,
	output logic [2:0]            task_prio_out
);

	localparam int TW = pts_pkg::TASK_W;
	localparam int PW = pts_pkg::PRIO_W;

	pts_pkg::mode_t       mode_q;
	logic [3:0]           id_q;
	logic [PW-1:0]        pr_q;
	logic [TW-1:0]        tgt_q;

	pts_pkg::slot_state_t state_q [pts_pkg::TASK_SLOTS];
	logic [PW-1:0]        prio_q  [pts_pkg::TASK_SLOTS];
	logic [TW-1:0]        next_q  [pts_pkg::TASK_SLOTS];
	logic [TW-1:0]        prev_q  [pts_pkg::TASK_SLOTS];
	logic [TW-1:0]        head_q  [pts_pkg::PRIO_LEVELS];
	logic [TW-1:0]        tail_q  [pts_pkg::PRIO_LEVELS];
	logic [pts_pkg::PRIO_LEVELS-1:0] ne_q;
	logic [TW-1:0]        cur_q;
	logic                 on_q;
	logic                 busy_q;

	pts_pkg::status_t     code_q;
	logic [3:0]           res_q;
	logic                 sw_q;
	logic                 none_q;
	pts_pkg::slot_state_t qs_q;
	logic [PW-1:0]        qp_q;

	logic [PW-1:0]        pr_sat;
	logic [TW-1:0]        id_idx;
	logic [TW-1:0]        free_idx;
	logic                 free_found;
	logic [TW-1:0]        tgt_d;
	logic [TW-1:0]        at_t;
	logic [PW-1:0]        ap_p;
	logic [TW-1:0]        ap_tl;
	logic [TW-1:0]        rm_t;
	logic [PW-1:0]        rm_p;
	logic [PW-1:0]        pk_p;
	logic                 pk_found;
	logic [TW-1:0]        pk_h;
	logic                 running_target;

	always_comb begin
		if (int'(priority_req) >= pts_pkg::PRIO_LEVELS) begin
			pr_sat = PW'(pts_pkg::PRIO_LEVELS - 1);
		end else begin
			pr_sat = PW'(priority_req);
		end
	end

	assign id_idx = TW'(id_q);

	// lowest dormant slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = pts_pkg::TASK_SLOTS - 1; i >= 0; i--) begin
			if (state_q[i] == pts_pkg::ST_DORMANT) begin
				free_found = 1'b1;
				free_idx   = TW'(i);
			end
		end
	end

	// highest non-empty queue
	always_comb begin
		pk_found = 1'b0;
		pk_p     = '0;
		for (int i = 0; i < pts_pkg::PRIO_LEVELS; i++) begin
			if (ne_q[i]) begin
				pk_found = 1'b1;
				pk_p     = PW'(i);
			end
		end
	end

	assign pk_h  = head_q[pk_p];
	assign tgt_d = (mode_q == pts_pkg::MODE_CREATE) ? free_idx : id_idx;
	assign at_t  = cmd.app_cur ? cur_q : tgt_q;
	assign ap_p  = prio_q[at_t];
	assign ap_tl = tail_q[ap_p];
	assign rm_t  = id_idx;
	assign rm_p  = prio_q[rm_t];
	assign running_target = on_q && busy_q && (id_idx == cur_q);

	assign sts.mode           = mode_q;
	assign sts.id_bad         = (int'(id_q) >= pts_pkg::TASK_SLOTS);
	assign sts.tgt_state      = state_q[id_idx];
	assign sts.running_target = running_target;
	assign sts.sched_on       = on_q;
	assign sts.busy           = busy_q;
	assign sts.cur_ready      = (state_q[cur_q] == pts_pkg::ST_READY);
	assign sts.free_found     = free_found;

	// command word and target slot
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= pts_pkg::mode_t'(mode);
			id_q   <= task_id;
			pr_q   <= pr_sat;
		end
		// hold the slot that a later append works on
		if (cmd.wr_state || cmd.wr_prio) begin
			tgt_q <= tgt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= pts_pkg::STS_OK;
			res_q  <= '0;
			sw_q   <= 1'b0;
			none_q <= 1'b0;
			qs_q   <= pts_pkg::ST_DORMANT;
			qp_q   <= '0;
		end else begin
			if (cmd.capture) begin
				code_q <= pts_pkg::STS_OK;
				res_q  <= task_id;
				sw_q   <= 1'b0;
				none_q <= 1'b0;
				qs_q   <= pts_pkg::ST_DORMANT;
				qp_q   <= '0;
			end
			if (cmd.set_code) begin
				code_q <= cmd.code;
			end
			if (cmd.res_zero) begin
				res_q <= '0;
			end
			if (cmd.res_free) begin
				res_q <= 4'(free_idx);
			end
			if (cmd.query) begin
				qs_q <= state_q[id_idx];
				qp_q <= prio_q[id_idx];
			end
			if (cmd.pick) begin
				if (pk_found) begin
					sw_q <= !busy_q || (pk_h != cur_q);
				end else begin
					sw_q   <= busy_q;
					none_q <= 1'b1;
				end
			end
		end
	end

	// slot table and scheduler flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pts_pkg::TASK_SLOTS; i++) begin
				state_q[i] <= pts_pkg::ST_DORMANT;
				prio_q[i]  <= '0;
			end
			cur_q  <= '0;
			on_q   <= 1'b0;
			busy_q <= 1'b0;
		end else begin
			if (cmd.wr_state) begin
				state_q[tgt_d] <= cmd.state_val;
			end
			if (cmd.wr_prio) begin
				prio_q[tgt_d] <= pr_q;
			end
			if (cmd.set_on) begin
				on_q <= 1'b1;
			end
			if (cmd.pick) begin
				busy_q <= pk_found;
				if (pk_found) begin
					cur_q <= pk_h;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ne_q <= '0;
		end else if (cmd.append) begin
			ne_q[ap_p] <= 1'b1;
		end else if (cmd.remove) begin
			if (ne_q[rm_p] && head_q[rm_p] == rm_t && head_q[rm_p] == tail_q[rm_p]) begin
				ne_q[rm_p] <= 1'b0;
			end
		end else if (cmd.pick && pk_found) begin
			if (pk_h == tail_q[pk_p]) begin
				ne_q[pk_p] <= 1'b0;
			end
		end
	end

	// links and queue ends
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			tail_q[ap_p] <= at_t;
			if (!ne_q[ap_p]) begin
				head_q[ap_p] <= at_t;
			end else begin
				next_q[ap_tl] <= at_t;
				prev_q[at_t]  <= ap_tl;
			end
		end else if (cmd.remove) begin
			if (ne_q[rm_p]) begin
				if (head_q[rm_p] == rm_t) begin
					if (head_q[rm_p] != tail_q[rm_p]) begin
						head_q[rm_p] <= next_q[rm_t];
					end
				end else if (tail_q[rm_p] == rm_t) begin
					tail_q[rm_p] <= prev_q[rm_t];
				end else begin
					next_q[prev_q[rm_t]] <= next_q[rm_t];
					prev_q[next_q[rm_t]] <= prev_q[rm_t];
				end
			end
		end else if (cmd.pick && pk_found) begin
			if (pk_h != tail_q[pk_p]) begin
				head_q[pk_p] <= next_q[pk_h];
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status_code    <= code_q;
			result_task    <= res_q;
			running_task   <= 4'(cur_q);
			switched       <= sw_q;
			none_ready     <= none_q;
			task_state_out <= qs_q;
			task_prio_out  <= 3'(qp_q);
		end
	end

endmodule

FILE: hw/rtl/pts_ctrl.sv
// Command sequencer: decodes a word and steps the datapath through unlink, append and pick.
module pts_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  pts_pkg::dp_sts_t      sts,
	output pts_pkg::dp_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_APPEND,
		S_YAPP,
		S_PICK,
		S_OUT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   yield_q;
	logic   yield_d;
	logic   out_valid_q;

	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != S_IDLE);

	always_comb begin
		cmd       = '0;
		cmd.code  = pts_pkg::STS_OK;
		cmd.state_val = pts_pkg::ST_DORMANT;
		state_d   = state_q;
		yield_d   = yield_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = S_OUT;
				if (sts.id_bad && sts.mode != pts_pkg::MODE_CREATE &&
				    sts.mode != pts_pkg::MODE_START && sts.mode != pts_pkg::MODE_YIELD) begin
					cmd.set_code = 1'b1;
					cmd.code     = pts_pkg::STS_NO_TASK;
				end else begin
					case (sts.mode)
						pts_pkg::MODE_CREATE: begin
							if (sts.free_found) begin
								cmd.wr_state  = 1'b1;
								cmd.state_val = pts_pkg::ST_READY;
								cmd.wr_prio   = 1'b1;
								cmd.res_free  = 1'b1;
								yield_d       = 1'b0;
								state_d       = S_APPEND;
							end else begin
								cmd.set_code = 1'b1;
								cmd.code     = pts_pkg::STS_NO_FREE;
								cmd.res_zero = 1'b1;
							end
						end
						pts_pkg::MODE_START: begin
							if (sts.sched_on) begin
								cmd.set_code = 1'b1;
								cmd.code     = pts_pkg::STS_ILLEGAL;
							end else begin
								cmd.set_on = 1'b1;
								state_d    = S_PICK;
							end
						end
						pts_pkg::MODE_YIELD: begin
							state_d = sts.sched_on ? S_YAPP : S_OUT;
						end
						pts_pkg::MODE_SUSPEND: begin
							if (sts.running_target || sts.tgt_state == pts_pkg::ST_READY) begin
								cmd.remove    = !sts.running_target;
								cmd.wr_state  = 1'b1;
								cmd.state_val = pts_pkg::ST_SUSPENDED;
								state_d       = sts.sched_on ? S_YAPP : S_OUT;
							end else begin
								cmd.set_code = 1'b1;
								cmd.code     = pts_pkg::STS_ILLEGAL;
							end
						end
						pts_pkg::MODE_RESUME: begin
							if (sts.tgt_state != pts_pkg::ST_SUSPENDED) begin
								cmd.set_code = 1'b1;
								cmd.code     = pts_pkg::STS_ILLEGAL;
							end else begin
								cmd.wr_state  = 1'b1;
								cmd.state_val = pts_pkg::ST_READY;
								yield_d       = 1'b1;
								state_d       = S_APPEND;
							end
						end
						pts_pkg::MODE_TERMINATE: begin
							if (sts.tgt_state != pts_pkg::ST_DORMANT) begin
								cmd.remove    = (sts.tgt_state == pts_pkg::ST_READY) &&
								                !sts.running_target;
								cmd.wr_state  = 1'b1;
								cmd.state_val = pts_pkg::ST_DORMANT;
								state_d       = sts.sched_on ? S_YAPP : S_OUT;
							end
						end
						pts_pkg::MODE_SET_PRIO: begin
							if (sts.tgt_state != pts_pkg::ST_READY) begin
								cmd.set_code = 1'b1;
								cmd.code     = pts_pkg::STS_ILLEGAL;
							end else if (!sts.running_target) begin
								cmd.remove  = 1'b1;
								cmd.wr_prio = 1'b1;
								yield_d     = 1'b0;
								state_d     = S_APPEND;
							end else begin
								cmd.wr_prio = 1'b1;
								state_d     = sts.sched_on ? S_YAPP : S_OUT;
							end
						end
						default: begin
							cmd.query = 1'b1;
						end
					endcase
				end
			end
			S_APPEND: begin
				cmd.append = 1'b1;
				state_d    = (yield_q && sts.sched_on) ? S_YAPP : S_OUT;
			end
			S_YAPP: begin
				// requeue the running task, if any and still ready, before the pick
				if (sts.busy && sts.cur_ready) begin
					cmd.append  = 1'b1;
					cmd.app_cur = 1'b1;
				end
				state_d = S_PICK;
			end
			S_PICK: begin
				cmd.pick = 1'b1;
				state_d  = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			yield_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			yield_q <= yield_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_decides: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_DECIDE)
		else $error("accepted word did not reach decode");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || !out_stall))
		else $error("result overwrote a waiting word");

	a_pick_on: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pick |-> sts.sched_on)
		else $error("pick while scheduler stopped");

	a_rise_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result shown outside the output step");

endmodule

FILE: hw/rtl/priority_task_scheduler.sv
// Top level: one command word in, one result word out per command.
// After a command is accepted it passes decode, optional append, optional requeue of the
// running task and optional pick; its result is then registered in the output step.
// Input stalls until the result is loaded; loading waits while a shown word is stalled.
// Reset: arst_n clears all slots to dormant, priorities to zero, queues empty, scheduler stopped.
module priority_task_scheduler (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] mode,
	input  logic [3:0] task_id,
	input  logic [2:0] priority_req,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status_code,
	output logic [3:0] result_task,
	output logic [3:0] running_task,
	output logic       switched,
	output logic       none_ready,
	output logic [1:0] task_state_out,
	output logic [2:0] task_prio_out
);

	pts_pkg::dp_cmd_t cmd;
	pts_pkg::dp_sts_t sts;

	pts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	pts_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.mode           (mode),
		.task_id        (task_id),
		.priority_req   (priority_req),
		.status_code    (status_code),
		.result_task    (result_task),
		.running_task   (running_task),
		.switched       (switched),
		.none_ready     (none_ready),
		.task_state_out (task_state_out),
		.task_prio_out  (task_prio_out)
	);

endmodule
